// ----- sv/stt_pkg.sv -----
// Shared types, token codes and helper functions of the schema text tokenizer.
// Used by every module of the block; depends on nothing else.
package stt_pkg;

  localparam int PosBits = 24;
  localparam int OffBits = 24;
  localparam int LenBits = 16;
  localparam int QDepth  = 4;

  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
  localparam logic [OffBits-1:0] OffMax = {OffBits{1'b1}};
  localparam logic [LenBits-1:0] LenMax = {LenBits{1'b1}};

  localparam logic [1:0] ModeIdle  = 2'd0;
  localparam logic [1:0] ModeWord  = 2'd1;
  localparam logic [1:0] ModeQuote = 2'd2;

  localparam logic [4:0] KErr  = 5'd0;
  localparam logic [4:0] KReal = 5'd1;
  localparam logic [4:0] KStr  = 5'd2;
  localparam logic [4:0] KInt  = 5'd3;
  localparam logic [4:0] KBool = 5'd4;
  localparam logic [4:0] KOne      = 5'd5;
  localparam logic [4:0] KZeroOne  = 5'd6;
  localparam logic [4:0] KZeroMore = 5'd7;
  localparam logic [4:0] KOneMore  = 5'd8;
  localparam logic [4:0] KLBrace   = 5'd9;
  localparam logic [4:0] KRBrace   = 5'd10;
  localparam logic [4:0] KLParen   = 5'd11;
  localparam logic [4:0] KRParen   = 5'd12;
  localparam logic [4:0] KLBrack   = 5'd13;
  localparam logic [4:0] KRBrack   = 5'd14;
  localparam logic [4:0] KOr       = 5'd15;
  localparam logic [4:0] KTypedef  = 5'd16;
  localparam logic [4:0] KId       = 5'd17;
  localparam logic [4:0] KCallback = 5'd18;
  localparam logic [4:0] KCstr     = 5'd19;
  localparam logic [4:0] KEnd      = 5'd20;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChQuote = 8'h27;
  localparam logic [7:0] ChUnder = 8'h5F;

  localparam logic [31:0] WInt  = 32'h0069_6E74;
  localparam logic [31:0] WStr  = 32'h0073_7472;
  localparam logic [31:0] WBool = 32'h626F_6F6C;
  localparam logic [31:0] WReal = 32'h7265_616C;

  typedef struct packed {
    logic [4:0]         kind;
    logic [OffBits-1:0] offset;
    logic [LenBits-1:0] length;
    logic               last;
  } tok_t;

  // One queue entry holds every token that a single character causes.
  typedef struct packed {
    logic two;
    tok_t first;
    tok_t second;
  } pair_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_alpha(c) || (c >= "0" && c <= "9") || c == ChUnder;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      "!":     k = KOne;
      "?":     k = KZeroOne;
      "*":     k = KZeroMore;
      "+":     k = KOneMore;
      "{":     k = KLBrace;
      "}":     k = KRBrace;
      "(":     k = KLParen;
      ")":     k = KRParen;
      "[":     k = KLBrack;
      "]":     k = KRBrack;
      "|":     k = KOr;
      "@":     k = KTypedef;
      "#":     k = KCallback;
      default: k = KErr;
    endcase
    return k;
  endfunction

  function automatic logic [OffBits-1:0] sat_offset(input logic [PosBits-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return (w > 32'(OffMax)) ? OffMax : w[OffBits-1:0];
  endfunction

  function automatic logic [LenBits-1:0] span(input logic [PosBits-1:0] from,
                                              input logic [PosBits-1:0] to);
    logic [PosBits-1:0] d;
    logic [31:0]        w;
    d = (to >= from) ? (to - from) : '0;
    w = 32'(d);
    return (w > 32'(LenMax)) ? LenMax : w[LenBits-1:0];
  endfunction

  function automatic tok_t mk_tok(input logic [4:0] kind, input logic [PosBits-1:0] p,
                                  input logic [LenBits-1:0] len);
    tok_t t;
    t.kind   = kind;
    t.offset = sat_offset(p);
    t.length = len;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic [4:0] word_kind(input logic [LenBits-1:0] len,
                                           input logic [31:0] w);
    logic [4:0] k;
    k = KId;
    if (len == LenBits'(3)) begin
      if ({8'h00, w[23:0]} == WInt) k = KInt;
      else if ({8'h00, w[23:0]} == WStr) k = KStr;
    end else if (len == LenBits'(4)) begin
      if (w == WBool) k = KBool;
      else if (w == WReal) k = KReal;
    end
    return k;
  endfunction

endpackage

// ----- sv/schema_text_tokenizer_top.sv -----
// Top level of the schema text tokenizer: front end, token queue, back end.
// Depends on stt_pkg, stt_front, stt_queue and stt_back.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_stall_o   char_code_i
//   out      output     out_valid_o/out_stall_i token_kind_o, token_offset_o,
//                                               token_length_o, last_of_run_o
//
// One character is accepted per cycle while the four-entry token queue has room.
// A character's tokens are written into the token queue and then loaded into the output
// register of the back end; a character with two tokens shows them one after the other.
// Reset is asynchronous and active low and clears scan state and the queue.
// Stalling the output fills the queue, which then stalls the input.
module schema_text_tokenizer_top import stt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [4:0]         token_kind_o,
  output logic [OffBits-1:0] token_offset_o,
  output logic [LenBits-1:0] token_length_o,
  output logic               last_of_run_o
);

  logic  push, full, pop, empty;
  pair_t push_data, head;
  tok_t  out_tok;

  stt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .q_full_i    (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  stt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  stt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_head_i    (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_tok_o   (out_tok)
  );

  assign token_kind_o   = out_tok.kind;
  assign token_offset_o = out_tok.offset;
  assign token_length_o = out_tok.length;
  assign last_of_run_o  = out_tok.last;

endmodule

// ----- sv/stt_front.sv -----
// Front end of the tokenizer: accepts characters, keeps the scan state and
// forms the tokens of each character as one queue entry. Uses stt_pkg.
module stt_front import stt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       q_full_i,
  output logic       push_o,
  output pair_t      push_data_o
);

  logic [1:0]         mode_q, mode_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [PosBits-1:0] start_q, start_d;
  logic [31:0]        pre_q, pre_d;
  logic               accept;
  logic [1:0]         cnt;
  tok_t               t0, t1, tk;
  logic               idle_path;
  logic [PosBits-1:0] adv;
  logic [4:0]         pk;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    start_d   = start_q;
    pre_d     = pre_q;
    cnt       = 2'd0;
    t0        = '0;
    t1        = '0;
    tk        = '0;
    idle_path = 1'b0;
    adv       = (pos_q == PosMax) ? pos_q : pos_q + PosBits'(1);
    pk        = punct_kind(char_code_i);

    unique case (mode_q)
      ModeWord: begin
        if (is_word_char(char_code_i)) begin
          pre_d = {pre_q[23:0], char_code_i};
          pos_d = adv;
        end else begin
          t0        = mk_tok(word_kind(span(start_q, pos_q), pre_q), start_q,
                             span(start_q, pos_q));
          cnt       = 2'd1;
          idle_path = 1'b1;
        end
      end
      ModeQuote: begin
        if (char_code_i == ChQuote) begin
          t0     = mk_tok(KCstr, start_q, span(start_q, pos_q));
          cnt    = 2'd1;
          mode_d = ModeIdle;
          pos_d  = adv;
        end else if (char_code_i == ChNul) begin
          t0      = mk_tok(KErr, start_q, span(start_q, pos_q));
          t1      = mk_tok(KEnd, pos_q, '0);
          cnt     = 2'd2;
          mode_d  = ModeIdle;
          pos_d   = '0;
          start_d = '0;
          pre_d   = '0;
        end else begin
          pos_d = adv;
        end
      end
      default: begin
        idle_path = 1'b1;
      end
    endcase

    if (idle_path) begin
      mode_d = ModeIdle;
      if (char_code_i == ChNul) begin
        tk      = mk_tok(KEnd, pos_q, '0);
        pos_d   = '0;
        start_d = '0;
        pre_d   = '0;
      end else begin
        pos_d = adv;
        if (is_blank(char_code_i)) begin
          tk = '0;
        end else if (pk != KErr) begin
          tk = mk_tok(pk, pos_q, LenBits'(1));
        end else if (char_code_i == ChQuote) begin
          mode_d  = ModeQuote;
          start_d = adv;
        end else if (is_alpha(char_code_i)) begin
          mode_d  = ModeWord;
          start_d = pos_q;
          pre_d   = {24'h0, char_code_i};
        end else begin
          tk = mk_tok(KErr, pos_q, LenBits'(1));
        end
      end
      if (char_code_i == ChNul || (!is_blank(char_code_i) && char_code_i != ChQuote &&
          !(pk == KErr && is_alpha(char_code_i)))) begin
        if (cnt == 2'd0) t0 = tk;
        else t1 = tk;
        cnt = cnt + 2'd1;
      end
    end

    if (cnt == 2'd1) t0.last = 1'b1;
    else if (cnt == 2'd2) t1.last = 1'b1;
  end

  assign push_o             = accept && (cnt != 2'd0);
  assign push_data_o.two    = (cnt == 2'd2);
  assign push_data_o.first  = t0;
  assign push_data_o.second = t1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      pos_q   <= '0;
      start_q <= '0;
      pre_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      pre_q   <= pre_d;
    end
  end

  a_end_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && char_code_i == ChNul |=> pos_q == '0 && mode_q == ModeIdle)
    else $error("Position not cleared after end of text.");

endmodule

// ----- sv/stt_queue.sv -----
// Short queue of token entries between the front and back ends.
// Uses stt_pkg for the entry type and depth.
module stt_queue import stt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  pair_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output pair_t head_o
);

  localparam int PtrBits = $clog2(QDepth);

  pair_t              mem_q [QDepth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [PtrBits:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrBits+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PtrBits'(1);
      if (pop_i) rd_q <= rd_q + PtrBits'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + (PtrBits+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (PtrBits+1)'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("Push into a full queue.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("Pop from an empty queue.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrBits+1)'(QDepth))
    else $error("Queue count out of range.");

endmodule

// ----- sv/stt_back.sv -----
// Back end of the tokenizer: takes queue entries and hands out their tokens
// one at a time through an output register. Uses stt_pkg.
module stt_back import stt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_empty_i,
  input  pair_t q_head_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output tok_t  out_tok_o
);

  logic valid_q;
  tok_t tok_q;
  logic sec_v_q;
  tok_t sec_q;
  logic free;

  assign free  = !valid_q || !out_stall_i;
  assign pop_o = free && !sec_v_q && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sec_v_q <= 1'b0;
    end else if (free) begin
      if (sec_v_q) begin
        valid_q <= 1'b1;
        sec_v_q <= 1'b0;
      end else begin
        valid_q <= !q_empty_i;
        sec_v_q <= !q_empty_i && q_head_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free) begin
      if (sec_v_q) begin
        tok_q <= sec_q;
      end else begin
        tok_q <= q_head_i.first;
        sec_q <= q_head_i.second;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_tok_o   = tok_q;

  a_second_behind_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_v_q |-> valid_q && !tok_q.last)
    else $error("Second token pending without its first token shown.");

endmodule

// ----- tb/sv/tb_schema_text_tokenizer_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for schema_text_tokenizer_top: drives character requests, predicts
// the token stream with a local model of the scanner and compares every token that comes out.
// Depends on stt_pkg and the RTL of the block.
module tb_schema_text_tokenizer_top;
  import stt_pkg::*;

  localparam int MaxCycles = 1000000;
  localparam int LongRun   = 20;

  typedef struct packed {
    logic [4:0]         kind;
    logic [OffBits-1:0] offset;
    logic [LenBits-1:0] length;
    logic               last;
  } token_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [7:0]         char_code_i = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [4:0]         token_kind_o;
  logic [OffBits-1:0] token_offset_o;
  logic [LenBits-1:0] token_length_o;
  logic               last_of_run_o;

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int chars_sent     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  token_t pending_tokens[$];

  logic [1:0]         scan_state  = ModeIdle;
  logic [PosBits-1:0] next_pos    = '0;
  logic [PosBits-1:0] open_start  = '0;
  logic [31:0]        recent_text = '0;

  string      word_list [12] = '{"int", "str", "bool", "real", "in", "intx", "boo", "reals",
                                 "xbool", "Int", "BOOL", "st"};
  string      punct_text     = "!?*+{}()[]|@#";
  logic [7:0] blank_chars [4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};

  schema_text_tokenizer_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .token_offset_o (token_offset_o),
    .token_length_o (token_length_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic word_char(input logic [7:0] c);
    return letter(c) || (c >= 8'h30 && c <= 8'h39) || c == ChUnder;
  endfunction

  function automatic logic blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic [4:0] punct_code(input logic [7:0] c);
    case (c)
      "!": return KOne;
      "?": return KZeroOne;
      "*": return KZeroMore;
      "+": return KOneMore;
      "{": return KLBrace;
      "}": return KRBrace;
      "(": return KLParen;
      ")": return KRParen;
      "[": return KLBrack;
      "]": return KRBrack;
      "|": return KOr;
      "@": return KTypedef;
      "#": return KCallback;
      default: return KErr;
    endcase
  endfunction

  function automatic logic [LenBits-1:0] clamp_len(input logic [PosBits-1:0] from,
                                                   input logic [PosBits-1:0] to);
    longint unsigned d;
    d = (to >= from) ? longint'(to) - longint'(from) : 0;
    return (d > longint'(LenMax)) ? LenMax : LenBits'(d);
  endfunction

  function automatic token_t make_token(input logic [4:0] kind, input logic [PosBits-1:0] off,
                                        input logic [LenBits-1:0] len);
    token_t t;
    t.kind   = kind;
    t.offset = (longint'(off) > longint'(OffMax)) ? OffMax : OffBits'(off);
    t.length = len;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic [4:0] keyword_or_id(input logic [LenBits-1:0] len);
    if (len == LenBits'(3) && recent_text[23:0] == WInt[23:0]) return KInt;
    if (len == LenBits'(3) && recent_text[23:0] == WStr[23:0]) return KStr;
    if (len == LenBits'(4) && recent_text == WBool) return KBool;
    if (len == LenBits'(4) && recent_text == WReal) return KReal;
    return KId;
  endfunction

  function automatic void step_pos();
    if (next_pos < PosMax) next_pos = next_pos + PosBits'(1);
  endfunction

  function automatic void clear_scan();
    scan_state  = ModeIdle;
    next_pos    = '0;
    open_start  = '0;
    recent_text = '0;
  endfunction

  // Advances the scanner by one character and queues the tokens it produces.
  function automatic void tokenize_char(input logic [7:0] c);
    token_t             made [2];
    int                 n;
    int                 i;
    logic [PosBits-1:0] p;
    logic [4:0]         pk;
    n  = 0;
    p  = next_pos;
    pk = punct_code(c);
    if (scan_state == ModeWord && word_char(c)) begin
      recent_text = {recent_text[23:0], c};
      step_pos();
    end else if (scan_state == ModeQuote && c != ChQuote && c != ChNul) begin
      step_pos();
    end else if (scan_state == ModeQuote) begin
      made[n] = make_token((c == ChQuote) ? KCstr : KErr, open_start, clamp_len(open_start, p));
      n = n + 1;
      if (c == ChQuote) begin
        scan_state = ModeIdle;
        step_pos();
      end else begin
        made[n] = make_token(KEnd, p, '0);
        n = n + 1;
        clear_scan();
      end
    end else begin
      if (scan_state == ModeWord) begin
        made[n] = make_token(keyword_or_id(clamp_len(open_start, p)), open_start,
                             clamp_len(open_start, p));
        n = n + 1;
      end
      scan_state = ModeIdle;
      if (c == ChNul) begin
        made[n] = make_token(KEnd, p, '0);
        n = n + 1;
        clear_scan();
      end else begin
        if (blank(c)) begin
        end else if (pk != KErr) begin
          made[n] = make_token(pk, p, LenBits'(1));
          n = n + 1;
        end else if (c == ChQuote) begin
          scan_state = ModeQuote;
          open_start = (p < PosMax) ? p + PosBits'(1) : PosMax;
        end else if (letter(c)) begin
          scan_state  = ModeWord;
          open_start  = p;
          recent_text = {24'h0, c};
        end else begin
          made[n] = make_token(KErr, p, LenBits'(1));
          n = n + 1;
        end
        step_pos();
      end
    end
    for (i = 0; i < n; i++) begin
      made[i].last = (i == n - 1);
      pending_tokens.push_back(made[i]);
    end
  endfunction

  task automatic send_char(input logic [7:0] c);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i  <= 1'b0;
      char_code_i <= 8'($urandom_range(0, 255));
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tokenize_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic test_words();
    send_text("int bool\tstr");
    send_char(8'h0D);
    send_text("real\nx_9 Z(boo q");
    send_char(ChNul);
  endtask

  task automatic test_punctuation();
    send_text(punct_text);
    send_char(ChNul);
  endtask

  // A closed string, an empty one, a word ended by a quote and a string left open at the end.
  task automatic test_strings();
    send_text("'ab''' k'x");
    send_char(ChNul);
  endtask

  task automatic test_unknown_chars();
    send_text("$1_");
    send_char(8'h7F);
    send_char(8'h80);
    send_char(8'hFF);
    send_char(ChNul);
  endtask

  // A long identifier and long strings, the last string left open at the end of text.
  task automatic test_long_tokens();
    send_char(ChNul);
    send_char("w");
    repeat (LongRun) send_char("_");
    send_char(" ");
    send_char(ChQuote);
    repeat (LongRun) send_char("s");
    send_char(ChQuote);
    send_char(ChQuote);
    repeat (LongRun) send_char("o");
    send_char(ChNul);
  endtask

  task automatic send_random_token();
    int         pick;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      send_text(word_list[$urandom_range(0, 11)]);
    end else if (pick < 38) begin
      send_char($urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122)));
      repeat ($urandom_range(0, 7)) begin
        case ($urandom_range(0, 3))
          0: c = 8'($urandom_range(65, 90));
          1: c = 8'($urandom_range(97, 122));
          2: c = 8'($urandom_range(48, 57));
          default: c = ChUnder;
        endcase
        send_char(c);
      end
    end else if (pick < 52) begin
      send_char(punct_text[$urandom_range(0, 12)]);
    end else if (pick < 64) begin
      send_char(ChQuote);
      repeat ($urandom_range(0, 6)) begin
        do c = 8'($urandom_range(1, 255)); while (c == ChQuote);
        send_char(c);
      end
      if ($urandom_range(0, 5) != 0) send_char(ChQuote);
    end else if (pick < 80) begin
      send_char(blank_chars[$urandom_range(0, 3)]);
    end else if (pick < 92) begin
      send_char(8'($urandom_range(0, 255)));
    end else begin
      send_char(ChNul);
    end
  endtask

  task automatic test_random_text(input int count);
    int start;
    start = chars_sent;
    while (chars_sent - start < count) send_random_token();
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);

  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tokens.size() == 0) begin
        $error("token with no request pending: kind %0d offset %0d", token_kind_o,
               token_offset_o);
        mismatch_count++;
      end else begin
        want = pending_tokens.pop_front();
        if (token_kind_o !== want.kind) begin
          $error("token_kind: expected %0d, actual %0d", want.kind, token_kind_o);
          mismatch_count++;
        end
        if (token_offset_o !== want.offset) begin
          $error("token_offset: expected %0d, actual %0d", want.offset, token_offset_o);
          mismatch_count++;
        end
        if (token_length_o !== want.length) begin
          $error("token_length: expected %0d, actual %0d", want.length, token_length_o);
          mismatch_count++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MaxCycles) begin
      $display("** schema_text_tokenizer_top: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 33;
    recv_idle_pct = 63;
    test_words();
    test_punctuation();
    test_strings();
    test_unknown_chars();
    test_random_text(100);

    send_idle_pct = 63;
    recv_idle_pct = 33;
    test_random_text(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_long_tokens();
    test_random_text(100);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** schema_text_tokenizer_top: PASSED **");
    end else begin
      $display("** schema_text_tokenizer_top: FAILED **");
    end
    $finish;
  end

endmodule
